// ===== design/uhid_pkg.sv =====
// shared types, constants and descriptor tables for the hid request responder
package uhid_pkg;

    localparam int EP0_PACKET_BYTES = 64;
    localparam int CONFIG_SET_BYTES = 41;
    localparam int REPORT_DESC_BYTES = 37;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_SETUP = 3'd0,
        OP_EP0_DONE = 3'd1,
        OP_BUS_RESET = 3'd2,
        OP_EP1_DONE = 3'd3,
        OP_SET_KEYS = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        KIND_STALL = 3'd0,
        KIND_DATA = 3'd1,
        KIND_ACK = 3'd2,
        KIND_ADDR = 3'd3,
        KIND_REPORT = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CFG_VENDOR = 2'd0,
        CFG_PRODUCT = 2'd1,
        CFG_RELEASE = 2'd2,
        CFG_POWER = 2'd3
    } cfg_idx_t;

    // which byte source a data run streams from
    typedef enum logic [2:0] {
        SRC_NONE = 3'd0,
        SRC_STATUS = 3'd1,
        SRC_DEVICE = 3'd2,
        SRC_CONFIG = 3'd3,
        SRC_HID = 3'd4,
        SRC_REPORT = 3'd5,
        SRC_KEYS = 3'd6
    } src_t;

    localparam logic [7:0] REQ_GET_STATUS = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
    localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIG = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIG = 8'd9;
    localparam logic [7:0] REQ_GET_INTERFACE = 8'd10;
    localparam logic [7:0] REQ_SET_INTERFACE = 8'd11;

    localparam logic [7:0] DT_DEVICE = 8'h01;
    localparam logic [7:0] DT_CONFIG = 8'h02;
    localparam logic [7:0] DT_HID = 8'h21;
    localparam logic [7:0] DT_REPORT = 8'h22;

    // one classified job handed from the front to the back
    typedef struct packed {
        kind_t kind;
        src_t src;
        logic [6:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
    } job_t;

    function automatic logic [7:0] hid_byte(input logic [5:0] i);
        logic [7:0] r;
        case (i)
            6'd0: r = 8'd9;
            6'd1: r = 8'h21;
            6'd2: r = 8'h11;
            6'd3: r = 8'h01;
            6'd4: r = 8'd0;
            6'd5: r = 8'd1;
            6'd6: r = 8'h22;
            6'd7: r = 8'(REPORT_DESC_BYTES);
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] report_byte(input logic [5:0] i);
        logic [7:0] r;
        case (i)
            6'd0: r = 8'h05;  6'd1: r = 8'h01;  6'd2: r = 8'h09;  6'd3: r = 8'h06;
            6'd4: r = 8'hA1;  6'd5: r = 8'h01;  6'd6: r = 8'h05;  6'd7: r = 8'h07;
            6'd8: r = 8'h19;  6'd9: r = 8'd224; 6'd10: r = 8'h29; 6'd11: r = 8'd231;
            6'd12: r = 8'h15; 6'd13: r = 8'd0;  6'd14: r = 8'h25; 6'd15: r = 8'd1;
            6'd16: r = 8'h75; 6'd17: r = 8'd1;  6'd18: r = 8'h95; 6'd19: r = 8'd8;
            6'd20: r = 8'h81; 6'd21: r = 8'h02; 6'd22: r = 8'h19; 6'd23: r = 8'd0;
            6'd24: r = 8'h29; 6'd25: r = 8'd101; 6'd26: r = 8'h15; 6'd27: r = 8'd0;
            6'd28: r = 8'h25; 6'd29: r = 8'd101; 6'd30: r = 8'h75; 6'd31: r = 8'd8;
            6'd32: r = 8'h95; 6'd33: r = 8'd1;  6'd34: r = 8'h81; 6'd35: r = 8'h00;
            6'd36: r = 8'hC0;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // configuration set minus the first nine header bytes and the hid bytes 18 to 26, handled elsewhere
    function automatic logic [7:0] config_tail_byte(input logic [5:0] i);
        logic [7:0] r;
        case (i)
            6'd9: r = 8'd9;   6'd10: r = 8'd4;  6'd11: r = 8'd0;  6'd12: r = 8'd0;
            6'd13: r = 8'd2;  6'd14: r = 8'd3;  6'd15: r = 8'd0;  6'd16: r = 8'd0;
            6'd17: r = 8'd0;
            6'd27: r = 8'd7;  6'd28: r = 8'd5;  6'd29: r = 8'h81; 6'd30: r = 8'd3;
            6'd31: r = 8'd64; 6'd32: r = 8'd0;  6'd33: r = 8'd1;
            6'd34: r = 8'd7;  6'd35: r = 8'd5;  6'd36: r = 8'h01; 6'd37: r = 8'd3;
            6'd38: r = 8'd64; 6'd39: r = 8'd0;  6'd40: r = 8'd1;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/uhid_front.sv =====
// front part: accepts events, updates request state and classifies replies
module uhid_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          op,
    input  logic [9:0]          setup_size,
    input  logic [7:0]          request_type,
    input  logic [7:0]          request_code,
    input  logic [15:0]         value_word,
    input  logic [15:0]         index_word,
    input  logic [15:0]         length_word,
    input  logic [7:0]          modifier_keys,
    input  logic [7:0]          key_code,
    output logic                job_valid,
    input  logic                job_full,
    output uhid_pkg::job_t      job,
    output logic [6:0]          addr_now,
    output logic                conf_now
);

    logic       configured_reg, configured_next;
    logic [7:0] saved_type_reg, saved_type_next;
    logic [7:0] saved_code_reg, saved_code_next;
    logic [6:0] saved_addr_reg, saved_addr_next;
    logic [6:0] address_reg, address_next;
    logic [7:0] mods_reg, mods_next;
    logic [7:0] key_reg, key_next;

    logic       accept;
    logic       emit;
    uhid_pkg::job_t j;
    logic [6:0] full_len;
    logic       known;
    logic [4:0] rcp;

    assign in_stall = job_full;
    assign accept = in_valid && !job_full;
    assign addr_now = address_next;
    assign conf_now = configured_next;

    // classify the event and compute next request state
    always_comb
    begin
        configured_next = configured_reg;
        saved_type_next = saved_type_reg;
        saved_code_next = saved_code_reg;
        saved_addr_next = saved_addr_reg;
        address_next = address_reg;
        mods_next = mods_reg;
        key_next = key_reg;
        emit = 1'b0;
        j.kind = uhid_pkg::KIND_STALL;
        j.src = uhid_pkg::SRC_NONE;
        j.len = 7'd0;
        j.b0 = 8'd0;
        j.b1 = 8'd0;
        full_len = 7'd0;
        known = 1'b0;
        rcp = request_type[4:0];
        if (accept)
        begin
            case (uhid_pkg::op_t'(op))
                uhid_pkg::OP_SETUP:
                begin
                    emit = 1'b1;
                    if (setup_size == 10'd8)
                    begin
                        saved_type_next = request_type;
                        saved_code_next = request_code;
                        saved_addr_next = value_word[6:0];
                        case (request_code)
                            uhid_pkg::REQ_GET_STATUS:
                            begin
                                if ((rcp == 5'd0)
                                    || (rcp == 5'd1 && index_word == 16'd0 && configured_reg)
                                    || (rcp == 5'd2 && index_word <= 16'd1
                                        && (configured_reg || index_word == 16'd0)))
                                begin
                                    j.kind = uhid_pkg::KIND_DATA;
                                    j.src = uhid_pkg::SRC_STATUS;
                                    j.len = 7'd2;
                                end
                            end
                            uhid_pkg::REQ_CLEAR_FEATURE:
                                if (value_word == 16'd1) j.kind = uhid_pkg::KIND_ACK;
                            uhid_pkg::REQ_SET_ADDRESS:
                                j.kind = uhid_pkg::KIND_ACK;
                            uhid_pkg::REQ_GET_DESCRIPTOR:
                            begin
                                known = 1'b1;
                                case (value_word[15:8])
                                    uhid_pkg::DT_DEVICE:
                                    begin
                                        j.src = uhid_pkg::SRC_DEVICE;
                                        full_len = 7'd18;
                                    end
                                    uhid_pkg::DT_CONFIG:
                                    begin
                                        j.src = uhid_pkg::SRC_CONFIG;
                                        full_len = 7'(uhid_pkg::CONFIG_SET_BYTES);
                                        known = (value_word[7:0] == 8'd0);
                                    end
                                    uhid_pkg::DT_HID:
                                    begin
                                        j.src = uhid_pkg::SRC_HID;
                                        full_len = 7'd9;
                                    end
                                    uhid_pkg::DT_REPORT:
                                    begin
                                        j.src = uhid_pkg::SRC_REPORT;
                                        full_len = 7'(uhid_pkg::REPORT_DESC_BYTES);
                                    end
                                    default: known = 1'b0;
                                endcase
                                if (!known)
                                    j.src = uhid_pkg::SRC_NONE;
                                else if (length_word == 16'd0)
                                begin
                                    j.kind = uhid_pkg::KIND_ACK;
                                    j.src = uhid_pkg::SRC_NONE;
                                end
                                else
                                begin
                                    j.kind = uhid_pkg::KIND_DATA;
                                    j.len = (length_word < {9'd0, full_len})
                                        ? length_word[6:0] : full_len;
                                end
                            end
                            uhid_pkg::REQ_GET_CONFIG:
                            begin
                                j.kind = uhid_pkg::KIND_DATA;
                                j.src = uhid_pkg::SRC_STATUS;
                                j.len = 7'd1;
                                j.b0 = {7'd0, configured_reg};
                            end
                            uhid_pkg::REQ_SET_CONFIG:
                            begin
                                if (value_word[7:0] <= 8'd1)
                                begin
                                    configured_next = value_word[0];
                                    j.kind = uhid_pkg::KIND_ACK;
                                end
                            end
                            uhid_pkg::REQ_GET_INTERFACE:
                            begin
                                if (configured_reg && index_word == 16'd0)
                                begin
                                    j.kind = uhid_pkg::KIND_DATA;
                                    j.src = uhid_pkg::SRC_STATUS;
                                    j.len = 7'd1;
                                end
                            end
                            uhid_pkg::REQ_SET_INTERFACE:
                                if (index_word == 16'd0 && value_word == 16'd0 && configured_reg)
                                    j.kind = uhid_pkg::KIND_ACK;
                            default: j.kind = uhid_pkg::KIND_STALL;
                        endcase
                    end
                end
                uhid_pkg::OP_EP0_DONE:
                begin
                    if (saved_type_reg == 8'd0 && saved_code_reg == uhid_pkg::REQ_SET_ADDRESS)
                    begin
                        address_next = saved_addr_reg;
                        emit = 1'b1;
                        j.kind = uhid_pkg::KIND_ADDR;
                    end
                end
                uhid_pkg::OP_BUS_RESET:
                begin
                    configured_next = 1'b0;
                    address_next = 7'd0;
                end
                uhid_pkg::OP_EP1_DONE:
                begin
                    emit = 1'b1;
                    j.kind = uhid_pkg::KIND_REPORT;
                    j.src = uhid_pkg::SRC_KEYS;
                    j.len = 7'd2;
                    j.b0 = mods_reg;
                    j.b1 = key_reg;
                    mods_next = 8'd0;
                    key_next = 8'd0;
                end
                uhid_pkg::OP_SET_KEYS:
                begin
                    mods_next = modifier_keys;
                    key_next = key_code;
                end
                default: emit = 1'b0;
            endcase
        end
    end

    assign job_valid = emit;
    assign job = j;

    // request state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            configured_reg <= 1'b0;
            saved_type_reg <= 8'd0;
            saved_code_reg <= 8'd0;
            saved_addr_reg <= 7'd0;
            address_reg <= 7'd0;
            mods_reg <= 8'd0;
            key_reg <= 8'd0;
        end
        else
        begin
            configured_reg <= configured_next;
            saved_type_reg <= saved_type_next;
            saved_code_reg <= saved_code_next;
            saved_addr_reg <= saved_addr_next;
            address_reg <= address_next;
            mods_reg <= mods_next;
            key_reg <= key_next;
        end
    end

endmodule

// ===== design/uhid_queue.sv =====
// short job queue between front and back
module uhid_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  uhid_pkg::job_t push_job,
    input  logic [6:0]     push_addr,
    input  logic           push_conf,
    output logic           full,
    output logic           not_empty,
    input  logic           pop,
    output uhid_pkg::job_t head_job,
    output logic [6:0]     head_addr,
    output logic           head_conf
);

    typedef struct packed {
        uhid_pkg::job_t j;
        logic [6:0]     a;
        logic           c;
    } entry_t;

    entry_t     mem_reg [uhid_pkg::QUEUE_DEPTH];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;

    assign full = (count_reg == 2'(uhid_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign head_job = mem_reg[rptr_reg].j;
    assign head_addr = mem_reg[rptr_reg].a;
    assign head_conf = mem_reg[rptr_reg].c;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= '{j: push_job, a: push_addr, c: push_conf};
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop) rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== design/uhid_back.sv =====
// back part: streams reply beats for one job at a time
module uhid_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_ready,
    input  uhid_pkg::job_t job,
    input  logic [6:0]     job_addr,
    input  logic           job_conf,
    output logic           job_pop,
    input  logic [15:0]    vendor_id,
    input  logic [15:0]    product_id,
    input  logic [15:0]    device_release,
    input  logic [7:0]     max_power_units,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [2:0]     reply_kind,
    output logic [7:0]     data_byte,
    output logic [6:0]     reply_length,
    output logic [6:0]     device_address,
    output logic           is_configured,
    output logic           last_of_run
);

    logic [5:0] idx_reg, idx_next;
    logic [6:0] cnt;
    logic [7:0] byte_val;
    logic       last;
    logic       fire;
    logic       take;

    // byte for the current position
    always_comb
    begin
        byte_val = 8'd0;
        case (job.src)
            uhid_pkg::SRC_STATUS: byte_val = job.b0;
            uhid_pkg::SRC_KEYS: byte_val = idx_reg[0] ? job.b1 : job.b0;
            uhid_pkg::SRC_HID: byte_val = uhid_pkg::hid_byte(idx_reg);
            uhid_pkg::SRC_REPORT: byte_val = uhid_pkg::report_byte(idx_reg);
            uhid_pkg::SRC_DEVICE:
            begin
                case (idx_reg)
                    6'd0: byte_val = 8'd18;
                    6'd1: byte_val = 8'd1;
                    6'd3: byte_val = 8'h02;
                    6'd7: byte_val = 8'(uhid_pkg::EP0_PACKET_BYTES);
                    6'd8: byte_val = vendor_id[7:0];
                    6'd9: byte_val = vendor_id[15:8];
                    6'd10: byte_val = product_id[7:0];
                    6'd11: byte_val = product_id[15:8];
                    6'd12: byte_val = device_release[7:0];
                    6'd13: byte_val = device_release[15:8];
                    6'd17: byte_val = 8'd1;
                    default: byte_val = 8'd0;
                endcase
            end
            uhid_pkg::SRC_CONFIG:
            begin
                case (idx_reg)
                    6'd0: byte_val = 8'd9;
                    6'd1: byte_val = 8'd2;
                    6'd2: byte_val = 8'(uhid_pkg::CONFIG_SET_BYTES);
                    6'd4: byte_val = 8'd1;
                    6'd5: byte_val = 8'd1;
                    6'd7: byte_val = 8'h80;
                    6'd8: byte_val = max_power_units;
                    default:
                        if (idx_reg >= 6'd18 && idx_reg <= 6'd26)
                            byte_val = uhid_pkg::hid_byte(idx_reg - 6'd18);
                        else
                            byte_val = uhid_pkg::config_tail_byte(idx_reg);
                endcase
            end
            default: byte_val = 8'd0;
        endcase
    end

    // beat sequencing: one per cycle unless stalled, pop on last beat
    assign cnt = (job.kind == uhid_pkg::KIND_DATA || job.kind == uhid_pkg::KIND_REPORT)
        ? job.len : 7'd1;
    assign last = ({1'b0, idx_reg} + 7'd1 == cnt);
    assign take = !out_valid || !out_stall;
    assign fire = job_ready && take;
    assign job_pop = fire && last;
    assign idx_next = job_pop ? 6'd0 : (fire ? idx_reg + 6'd1 : idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 6'd0;
            out_valid <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (take) out_valid <= job_ready;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            reply_kind <= job.kind;
            data_byte <= byte_val;
            reply_length <= job.len;
            device_address <= job_addr;
            is_configured <= job_conf;
            last_of_run <= last;
        end
    end

endmodule

// ===== design/usb_hid_control_request_responder.sv =====
// top level of the usb hid keyboard control request responder
// One input beat is taken per cycle while the two-entry job queue has room;
// events that give no reply (bus reset, key update, plain EP0 done) finish in
// that cycle. A reply streams from the back part one beat per cycle unless
// out_stall holds it: one beat for stall, ack or address, two for a key
// report, one or two for status, up to 41 for a descriptor. The first beat is
// registered in the job queue, then in the back output register. The device
// address and configured flag on each beat are those after the causing item.
module usb_hid_control_request_responder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [9:0]  setup_size,
    input  logic [7:0]  request_type,
    input  logic [7:0]  request_code,
    input  logic [15:0] value_word,
    input  logic [15:0] index_word,
    input  logic [15:0] length_word,
    input  logic [7:0]  modifier_keys,
    input  logic [7:0]  key_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  reply_kind,
    output logic [7:0]  data_byte,
    output logic [6:0]  reply_length,
    output logic [6:0]  device_address,
    output logic        is_configured,
    output logic        last_of_run
);

    logic [15:0] vendor_reg, product_reg, release_reg;
    logic [7:0]  power_reg;

    logic           push, full, not_empty, pop;
    uhid_pkg::job_t push_job, head_job;
    logic [6:0]     push_addr, head_addr;
    logic           push_conf, head_conf;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vendor_reg <= 16'h1209;
            product_reg <= 16'h000A;
            release_reg <= 16'h0010;
            power_reg <= 8'd50;
        end
        else if (cfg_valid)
        begin
            case (uhid_pkg::cfg_idx_t'(cfg_index))
                uhid_pkg::CFG_VENDOR: vendor_reg <= cfg_data;
                uhid_pkg::CFG_PRODUCT: product_reg <= cfg_data;
                uhid_pkg::CFG_RELEASE: release_reg <= cfg_data;
                uhid_pkg::CFG_POWER: power_reg <= cfg_data[7:0];
                default: power_reg <= power_reg;
            endcase
        end
    end

    uhid_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .op, .setup_size, .request_type,
        .request_code, .value_word, .index_word, .length_word, .modifier_keys,
        .key_code,
        .job_valid(push), .job_full(full), .job(push_job),
        .addr_now(push_addr), .conf_now(push_conf)
    );

    uhid_queue u_queue (
        .clk, .rst_n, .push, .push_job, .push_addr, .push_conf, .full,
        .not_empty, .pop, .head_job, .head_addr, .head_conf
    );

    uhid_back u_back (
        .clk, .rst_n, .job_ready(not_empty), .job(head_job), .job_addr(head_addr),
        .job_conf(head_conf), .job_pop(pop),
        .vendor_id(vendor_reg), .product_id(product_reg),
        .device_release(release_reg), .max_power_units(power_reg),
        .out_valid, .out_stall, .reply_kind, .data_byte, .reply_length,
        .device_address, .is_configured, .last_of_run
    );

endmodule

// ===== design/uhid_checker.sv =====
// port-level checks for the hid request responder
module uhid_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] reply_kind,
    input logic [6:0] reply_length,
    input logic       last_of_run
);

    // a stalled result beat keeps its kind
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(reply_kind))
        else $error("stalled beat changed");

    // stall, ack and address beats are single-beat runs
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (reply_kind == uhid_pkg::KIND_STALL || reply_kind == uhid_pkg::KIND_ACK
                      || reply_kind == uhid_pkg::KIND_ADDR)
        |-> last_of_run && reply_length == 7'd0)
        else $error("single beat not marked last");

    // report beats carry length two
    a_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_kind == uhid_pkg::KIND_REPORT |-> reply_length == 7'd2)
        else $error("report length wrong");

    // data beats never exceed the longest descriptor
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_kind == uhid_pkg::KIND_DATA
        |-> reply_length != 7'd0 && reply_length <= 7'(uhid_pkg::CONFIG_SET_BYTES))
        else $error("data length out of range");

endmodule

bind usb_hid_control_request_responder uhid_checker u_uhid_checker (
    .clk, .rst_n, .out_valid, .out_stall, .reply_kind, .reply_length, .last_of_run
);
